### rtl/sirs_pkg.sv
// Shared constants for the signed integer to radix symbol converter.
package sirs_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_RADIX   = 16;
  localparam int ALPHA_SYMS  = 16;
  localparam int DIGIT_W     = 4;
  localparam int STEP_BITS   = 4;
  localparam int STEPS       = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int MAG_W       = STEPS * STEP_BITS;
  localparam int STEP_CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int DIGIT_DEPTH = VALUE_BITS;
  localparam int DCNT_W      = $clog2(DIGIT_DEPTH + 1);
  localparam int RADIX_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_SPACE = 8'h20;
  localparam logic [7:0] SYM_NUL   = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd2;

  localparam logic [63:0] ALPHA_LOW_RST  = 64'h3736353433323130;
  localparam logic [63:0] ALPHA_HIGH_RST = 64'h0000000000003938;
  localparam logic [RADIX_W-1:0] RADIX_RST = 5'd10;

endpackage

### rtl/signed_int_to_radix_symbols_core.sv
// Signed integer to radix symbol converter, top level.
//
// Usage: an item on the input channel (value_i) is a signed number. The block
// emits its text on the output channel, one symbol per item: a '-' first for a
// negative value, then digits most significant first, is_last_o on the final
// one. If the alphabet or radix fails validation a single item with symbol 0,
// base_invalid_o and is_last_o set is emitted instead.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and must only be issued while the block is idle.
// Per input item: validation walks one alphabet symbol per cycle over the
// first radix symbols (an out-of-range radix fails on the first check); each
// digit is then found by the 4-bit serial divider; symbols leave the digit
// stack one per cycle while the receiver is ready. One item is converted at
// a time; a new item is accepted as soon as the last symbol sits in the
// output register.
// A stalled receiver holds the output register and freezes the symbol walk.
// Reset restores the default alphabet "0123456789" with radix 10 and
// leaves the block idle with no output pending.
module signed_int_to_radix_symbols_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sirs_pkg::VALUE_BITS-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          symbol_o,
  output logic                                is_last_o,
  output logic                                base_invalid_o,
  input  logic                                cfg_we_i,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef logic [sirs_pkg::DIGIT_W-1:0] digit_t;

  state_e state_q, state_d;

  logic [63:0] alpha_low_q, alpha_high_q;
  logic [sirs_pkg::RADIX_W-1:0] radix_q;

  logic [sirs_pkg::MAG_W-1:0]      mag_q, mag_d;
  logic [sirs_pkg::DIGIT_W-1:0]    rem_q, rem_d;
  logic [sirs_pkg::STEP_CNT_W-1:0] step_q, step_d;
  logic [sirs_pkg::DCNT_W-1:0]     cnt_q, cnt_d;
  logic [3:0]                      chk_q, chk_d;
  logic                            neg_q, neg_d;
  digit_t                          digits_q [sirs_pkg::DIGIT_DEPTH];
  digit_t                          digits_d [sirs_pkg::DIGIT_DEPTH];

  logic       out_valid_q, out_valid_d;
  logic [7:0] sym_q, sym_d;
  logic       last_q, last_d;
  logic       inv_q, inv_d;

  logic       out_free;
  logic [7:0] chk_sym;
  logic       radix_bad;
  logic       sym_bad;
  logic       chk_end;
  logic [7:0] div_res;
  logic [sirs_pkg::MAG_W-1:0] mag_shift;
  logic [sirs_pkg::VALUE_BITS-1:0] in_mag;

  function automatic logic [7:0] sym_at(logic [63:0] lo, logic [63:0] hi, logic [3:0] idx);
    logic [63:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

  // One radix-16 step of long division: x < 16 * b gives a 4-bit quotient.
  function automatic logic [7:0] div_step(logic [7:0] x, logic [sirs_pkg::RADIX_W-1:0] b);
    logic [8:0] r;
    logic [8:0] sub;
    logic [3:0] q;
    r = {1'b0, x};
    q = '0;
    for (int k = 3; k >= 0; k--) begin
      sub = {4'b0000, b} << k;
      if (r >= sub) begin
        r = r - sub;
        q[k] = 1'b1;
      end
    end
    return {q, r[3:0]};
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= sirs_pkg::ALPHA_LOW_RST;
      alpha_high_q <= sirs_pkg::ALPHA_HIGH_RST;
      radix_q      <= sirs_pkg::RADIX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sirs_pkg::REG_ALPHA_LOW:  alpha_low_q  <= cfg_data_i[63:0];
        sirs_pkg::REG_ALPHA_HIGH: alpha_high_q <= cfg_data_i[63:0];
        sirs_pkg::REG_RADIX:      radix_q      <= cfg_data_i[sirs_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_mag = value_i[sirs_pkg::VALUE_BITS-1] ?
                  (~value_i + sirs_pkg::VALUE_BITS'(1)) : value_i;

  // Validation of the symbol under check against the forbidden set and the
  // symbols after it.
  always_comb begin
    chk_sym   = sym_at(alpha_low_q, alpha_high_q, chk_q);
    radix_bad = (radix_q < 5'd2) || (radix_q > 5'(sirs_pkg::MAX_RADIX));
    sym_bad   = (chk_sym == sirs_pkg::SYM_PLUS) || (chk_sym == sirs_pkg::SYM_MINUS) ||
                (chk_sym == sirs_pkg::SYM_SPACE) || (chk_sym == sirs_pkg::SYM_NUL);
    for (int j = 0; j < sirs_pkg::ALPHA_SYMS; j++) begin
      if ((5'(j) > {1'b0, chk_q}) && (5'(j) < radix_q) &&
          (sym_at(alpha_low_q, alpha_high_q, 4'(j)) == chk_sym)) begin
        sym_bad = 1'b1;
      end
    end
    chk_end = ({1'b0, chk_q} == (radix_q - 5'd1));
  end

  assign div_res   = div_step({rem_q, mag_q[sirs_pkg::MAG_W-1 -: sirs_pkg::STEP_BITS]},
                              radix_q);
  assign mag_shift = {mag_q[sirs_pkg::MAG_W-sirs_pkg::STEP_BITS-1:0], div_res[7:4]};

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    chk_d       = chk_q;
    neg_d       = neg_q;
    digits_d    = digits_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sym_d       = sym_q;
    last_d      = last_q;
    inv_d       = inv_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mag_d   = sirs_pkg::MAG_W'(in_mag);
          neg_d   = value_i[sirs_pkg::VALUE_BITS-1];
          chk_d   = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (radix_bad || sym_bad) begin
          // Hold until the output register frees, then flag the base.
          if (out_free) begin
            out_valid_d = 1'b1;
            sym_d       = sirs_pkg::SYM_NUL;
            last_d      = 1'b1;
            inv_d       = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (chk_end) begin
          rem_d   = '0;
          step_d  = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          chk_d = chk_q + 4'd1;
        end
      end
      ST_DIV: begin
        mag_d = mag_shift;
        rem_d = div_res[3:0];
        if (step_q == sirs_pkg::STEP_CNT_W'(sirs_pkg::STEPS - 1)) begin
          // Remainder is the next digit; push it onto the stack.
          digits_d[0] = div_res[3:0];
          for (int k = 1; k < sirs_pkg::DIGIT_DEPTH; k++) begin
            digits_d[k] = digits_q[k-1];
          end
          cnt_d  = cnt_q + sirs_pkg::DCNT_W'(1);
          rem_d  = '0;
          step_d = '0;
          if (mag_shift == '0) begin
            state_d = ST_EMIT;
          end
        end else begin
          step_d = step_q + sirs_pkg::STEP_CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          inv_d       = 1'b0;
          if (neg_q) begin
            sym_d  = sirs_pkg::SYM_MINUS;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            // Pop the most significant digit.
            sym_d  = sym_at(alpha_low_q, alpha_high_q, digits_q[0]);
            last_d = (cnt_q == sirs_pkg::DCNT_W'(1));
            for (int k = 0; k < sirs_pkg::DIGIT_DEPTH - 1; k++) begin
              digits_d[k] = digits_q[k+1];
            end
            digits_d[sirs_pkg::DIGIT_DEPTH-1] = '0;
            cnt_d = cnt_q - sirs_pkg::DCNT_W'(1);
            if (cnt_q == sirs_pkg::DCNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      chk_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      chk_q       <= chk_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    rem_q    <= rem_d;
    digits_q <= digits_d;
    sym_q    <= sym_d;
    last_q   <= last_d;
    inv_q    <= inv_d;
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = sym_q;
  assign is_last_o      = last_q;
  assign base_invalid_o = inv_q;

  a_inv_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && base_invalid_o |-> is_last_o && (symbol_o == sirs_pkg::SYM_NUL))
    else $error("invalid-base item malformed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while conversion still running");

  a_emit_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0))
    else $error("digit stack empty while emitting");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sirs_pkg::DCNT_W'(sirs_pkg::DIGIT_DEPTH))
    else $error("digit stack overflow");

endmodule
